// ===== hdl/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// shared types and constants of the sorted priority message queue
// ----------------------------------------------------------------------------
package spmq_pkg;

	localparam int PRI_W           = 8;
	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_HEAD    = 2'd1,
		OP_EXACT   = 2'd2,
		OP_ATLEAST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage

// ===== hdl/spmq_ram.sv =====
// ----------------------------------------------------------------------------
// spmq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module spmq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/spmq_seq.sv =====
// ----------------------------------------------------------------------------
// spmq_seq
// sequencer that walks the sorted store one entry at a time, shifting
// entries up on insert and down on removal, with the result register
// ----------------------------------------------------------------------------
module spmq_seq #(
	parameter int DEPTH       = spmq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = spmq_pkg::VALUE_WIDTH_DEF,
	localparam int CNT_W      = $clog2(DEPTH + 1),
	localparam int IDX_W      = $clog2(DEPTH),
	localparam int ENTRY_W    = VALUE_WIDTH + spmq_pkg::PRI_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input item
	input  logic                        in_valid,
	output logic                        in_ready,
	input  spmq_pkg::op_t               in_op,
	input  logic [spmq_pkg::PRI_W-1:0]  in_pri,
	input  logic [VALUE_WIDTH-1:0]      in_val,
	// result item
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [VALUE_WIDTH-1:0]      out_val,
	output logic [spmq_pkg::PRI_W-1:0]  out_pri,
	output spmq_pkg::status_t           out_status,
	output logic [CNT_W-1:0]            out_occ,
	// store
	output logic                        ram_we,
	output logic [IDX_W-1:0]            ram_waddr,
	output logic [ENTRY_W-1:0]          ram_wdata,
	output logic [IDX_W-1:0]            ram_raddr,
	input  logic [ENTRY_W-1:0]          ram_rdata
);

	import spmq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_PUT,
		S_DONE
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [PRI_W-1:0]  key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              found_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic [PRI_W-1:0]  res_pri_q;
	status_t           res_st_q;

	logic              out_valid_q;
	logic [VALUE_WIDTH-1:0] out_val_q;
	logic [PRI_W-1:0]  out_pri_q;
	status_t           out_st_q;
	logic [CNT_W-1:0]  out_occ_q;

	logic [PRI_W-1:0]       rd_pri;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic                   hit;
	logic                   last;
	logic                   full;
	logic                   accept;
	logic                   load_out;

	assign rd_pri   = ram_rdata[PRI_W-1:0];
	assign rd_val   = ram_rdata[ENTRY_W-1:PRI_W];
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign last     = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		case (op_q)
			OP_HEAD:  hit = (idx_q == '0);
			OP_EXACT: hit = (rd_pri == key_q);
			default:  hit = (rd_pri >= key_q);
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q;
		case (state_q)
			S_CHK: begin
				if (op_q == OP_INSERT) begin
					// entry above the key moves up, otherwise the new item lands above it
					ram_we    = 1'b1;
					ram_waddr = idx_q + IDX_W'(1);
					if (rd_pri <= key_q) begin
						ram_wdata = {val_q, key_q};
					end
				end else if (found_q) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q - IDX_W'(1);
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = {val_q, key_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= in_op;
						key_q     <= in_pri;
						val_q     <= in_val;
						found_q   <= 1'b0;
						res_val_q <= '0;
						res_pri_q <= '0;
						res_st_q  <= ST_OK;
						if (in_op == OP_INSERT) begin
							if (full) begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end else if (cnt_q == '0) begin
								idx_q   <= '0;
								state_q <= S_PUT;
							end else begin
								idx_q   <= IDX_W'(cnt_q - CNT_W'(1));
								state_q <= S_RD;
							end
						end else if (cnt_q == '0) begin
							res_st_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							idx_q   <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (op_q == OP_INSERT) begin
						if (rd_pri <= key_q) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_DONE;
						end else if (idx_q == '0) begin
							state_q <= S_PUT;
						end else begin
							idx_q   <= idx_q - IDX_W'(1);
							state_q <= S_RD;
						end
					end else begin
						if (!found_q && hit) begin
							found_q   <= 1'b1;
							res_val_q <= rd_val;
							res_pri_q <= rd_pri;
						end
						if (last) begin
							if (found_q || hit) begin
								cnt_q <= cnt_q - CNT_W'(1);
							end else begin
								res_st_q <= ST_NOMATCH;
							end
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val_q;
						out_pri_q   <= res_pri_q;
						out_st_q    <= res_st_q;
						out_occ_q   <= cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_val    = out_val_q;
	assign out_pri    = out_pri_q;
	assign out_status = out_st_q;
	assign out_occ    = out_occ_q;

endmodule

// ===== hdl/sorted_priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_message_queue
// bounded queue of priority and value pairs kept in ascending priority order
// ----------------------------------------------------------------------------
// channel   dir  tdata                                tuser
// s_axis    in   priority_req, value_in               operation
// m_axis    out  value_out, priority_out, occupancy   status
//
// each item walks the store through its single port, one entry per read and
// compare step: a take visits every held entry, an insert each entry that it
// shifts up and the one at which it stops; an empty take or a full insert needs
// no walk, and no new item is taken until the last result is in the output register
// reset empties the queue at once; the store itself needs no clearing
// a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
module sorted_priority_message_queue #(
	parameter int DEPTH       = spmq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = spmq_pkg::VALUE_WIDTH_DEF,
	localparam int CNT_W      = $clog2(DEPTH + 1),
	localparam int IN_W       = ((spmq_pkg::PRI_W + VALUE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W      = ((VALUE_WIDTH + spmq_pkg::PRI_W + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // priority_req, value_in
	input  logic [1:0]       s_axis_tuser,  // operation
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // value_out, priority_out, occupancy
	output logic [1:0]       m_axis_tuser   // status
);

	import spmq_pkg::*;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int ENTRY_W = VALUE_WIDTH + PRI_W;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]     ram_wdata;
	logic [IDX_W-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]     ram_rdata;

	logic [VALUE_WIDTH-1:0] out_val;
	logic [PRI_W-1:0]       out_pri;
	status_t                out_status;
	logic [CNT_W-1:0]       out_occ;

	spmq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	spmq_seq #(
		.DEPTH      (DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (op_t'(s_axis_tuser)),
		.in_pri    (s_axis_tdata[PRI_W-1:0]),
		.in_val    (s_axis_tdata[PRI_W +: VALUE_WIDTH]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_val   (out_val),
		.out_pri   (out_pri),
		.out_status(out_status),
		.out_occ   (out_occ),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[VALUE_WIDTH-1:0]             = out_val;
		m_axis_tdata[VALUE_WIDTH +: PRI_W]        = out_pri;
		m_axis_tdata[VALUE_WIDTH + PRI_W +: CNT_W] = out_occ;
	end

	assign m_axis_tuser = out_status;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_occ <= CNT_W'(DEPTH)))
		else $error("occupancy beyond depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status == ST_FULL) |-> (out_occ == CNT_W'(DEPTH)))
		else $error("full status with room left");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status == ST_EMPTY) |-> (out_occ == '0))
		else $error("empty status with entries held");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status != ST_OK) |-> (out_val == '0 && out_pri == '0))
		else $error("failed operation returned an entry");

endmodule

// ===== tb/tb_sorted_priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_message_queue
// self-checking bench for the sorted priority message queue: a scoreboard
// keeps its own sorted copy of the queue, predicts value, priority, status
// and occupancy for every accepted item and checks each result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_priority_message_queue;
	import spmq_pkg::*;

	localparam int DEPTH    = DEPTH_DEF;
	localparam int VAL_W    = VALUE_WIDTH_DEF;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int IN_W     = ((PRI_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_W    = ((VAL_W + PRI_W + CNT_W + 7) / 8) * 8;
	localparam int SETTLE   = 2 * DEPTH + 20;
	localparam int MAX_CYC  = 400000;
	localparam int N_RANDOM = 340;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [PRI_W-1:0] pri;
		status_t          status;
		logic [CNT_W-1:0] occ;
	} queue_result_t;

	class spmq_scoreboard;
		logic [PRI_W-1:0] pri_q[DEPTH];
		logic [VAL_W-1:0] val_q[DEPTH];
		int unsigned      held;
		int unsigned      max_held;
		queue_result_t    expected[$];
		int               mismatches;
		int               op_seen[4];
		int               status_seen[4];

		function void note_item(op_t op, logic [PRI_W-1:0] key, logic [VAL_W-1:0] val);
			queue_result_t r;
			int unsigned   pos;
			bit            found;
			r = '0;
			r.status = ST_OK;
			if (op == OP_INSERT) begin
				if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < held && pri_q[pos] <= key)
						pos++;
					for (int unsigned i = held; i > pos; i--) begin
						pri_q[i] = pri_q[i-1];
						val_q[i] = val_q[i-1];
					end
					pri_q[pos] = key;
					val_q[pos] = val;
					held++;
				end
			end else if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				found = (op == OP_HEAD);
				pos   = 0;
				if (!found) begin
					for (int unsigned i = 0; i < held; i++) begin
						if (!found && ((op == OP_EXACT) ? (pri_q[i] == key) : (pri_q[i] >= key))) begin
							found = 1'b1;
							pos   = i;
						end
					end
				end
				if (found) begin
					r.value = val_q[pos];
					r.pri   = pri_q[pos];
					for (int unsigned i = pos; i + 1 < held; i++) begin
						pri_q[i] = pri_q[i+1];
						val_q[i] = val_q[i+1];
					end
					held--;
				end else begin
					r.status = ST_NOMATCH;
				end
			end
			r.occ = CNT_W'(held);
			if (held > max_held)
				max_held = held;
			op_seen[op]++;
			status_seen[r.status]++;
			expected.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] data, logic [1:0] user);
			queue_result_t e;
			if (expected.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with nothing pending: data %h status %0d", $realtime, data, user);
				mismatches++;
				return;
			end
			e = expected.pop_front();
			if (data[VAL_W-1:0] !== e.value || data[VAL_W +: PRI_W] !== e.pri
					|| user !== e.status || data[VAL_W+PRI_W +: CNT_W] !== e.occ
					|| data[OUT_W-1:VAL_W+PRI_W+CNT_W] !== '0) begin
				if (mismatches < 10)
					$display("%0t: mismatch exp value %h pri %0d status %s occ %0d, got value %h pri %0d status %0d occ %0d pad %b",
						$realtime, e.value, e.pri, e.status.name(), e.occ,
						data[VAL_W-1:0], data[VAL_W +: PRI_W], user,
						data[VAL_W+PRI_W +: CNT_W], data[OUT_W-1:VAL_W+PRI_W+CNT_W]);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function logic [PRI_W-1:0] any_held_priority();
			if (held == 0)
				return PRI_W'($urandom_range(255));
			return pri_q[$urandom_range(held - 1)];
		endfunction
	endclass

	logic             clk            = 1'b0;
	logic             arst_n         = 1'b0;
	logic             s_axis_tvalid  = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata   = '0;  // priority_req, value_in
	logic [1:0]       s_axis_tuser   = '0;  // operation
	logic             m_axis_tvalid;
	logic             m_axis_tready  = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;         // value_out, priority_out, occupancy
	logic [1:0]       m_axis_tuser;         // status

	int             src_idle_pct = 0;
	int             sink_idle_pct = 0;
	int             hold_left = 0;
	int             cycles = 0;
	spmq_scoreboard sb = new;

	sorted_priority_message_queue #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VAL_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycles < MAX_CYC) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// receiver: random stalls, or a long hold-off while hold_left runs down
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_item(op_t'(s_axis_tuser), s_axis_tdata[PRI_W-1:0], s_axis_tdata[PRI_W +: VAL_W]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	task automatic send_item(input op_t op, input logic [PRI_W-1:0] key, input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= IN_W'({val, key});
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_random(input int ins_pct);
		op_t              op;
		logic [PRI_W-1:0] key;
		int               r;
		r = $urandom_range(99);
		if (r < ins_pct) begin
			op = OP_INSERT;
		end else begin
			r  = $urandom_range(99);
			op = (r < 30) ? OP_HEAD : ((r < 65) ? OP_EXACT : OP_ATLEAST);
		end
		r = $urandom_range(99);
		if (r < 35)
			key = PRI_W'($urandom_range(7));
		else if (r < 65)
			key = sb.any_held_priority();
		else if (r < 88)
			key = PRI_W'($urandom_range(255));
		else
			key = $urandom_range(1) ? 8'hff : 8'h00;
		send_item(op, key, VAL_W'($urandom()));
	endtask

	// alternate fill and drain stretches so the queue swings between empty and full
	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send_random(((i / 48) % 2) ? 30 : 75);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct  = 29;
		sink_idle_pct = 65;

		// empty queue, ties, no match, extremes, then fill past full
		send_item(OP_HEAD, 8'h00, 32'h0);
		send_item(OP_ATLEAST, 8'h00, 32'hffff_ffff);
		send_item(OP_INSERT, 8'hff, 32'hffff_ffff);
		send_item(OP_INSERT, 8'h00, 32'h0000_0000);
		send_item(OP_INSERT, 8'h80, 32'ha5a5_a5a5);
		send_item(OP_INSERT, 8'h80, 32'h5a5a_5a5a);
		send_item(OP_EXACT, 8'h07, 32'h0);
		send_item(OP_EXACT, 8'h80, 32'h0);
		send_item(OP_ATLEAST, 8'h81, 32'h0);
		send_item(OP_ATLEAST, 8'h00, 32'h0);
		for (int i = 0; i < DEPTH; i++)
			send_item(OP_INSERT, PRI_W'(255 - 17 * i), VAL_W'($urandom()));
		drain();

		run_random(N_RANDOM);
		drain();

		src_idle_pct  = 65;
		sink_idle_pct = 29;
		run_random(N_RANDOM);
		drain();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_left     = 300;
		for (int i = 0; i < 12; i++)
			send_random(60);
		drain();
		run_random(N_RANDOM);
		drain();

		$display("ran %0d items: %0d inserts, %0d head, %0d exact and %0d at-least takes",
			sb.op_seen[OP_INSERT] + sb.op_seen[OP_HEAD] + sb.op_seen[OP_EXACT] + sb.op_seen[OP_ATLEAST],
			sb.op_seen[OP_INSERT], sb.op_seen[OP_HEAD], sb.op_seen[OP_EXACT], sb.op_seen[OP_ATLEAST]);
		$display("status ok %0d, empty %0d, no match %0d, full %0d; peak occupancy %0d; %0d mismatches",
			sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOMATCH],
			sb.status_seen[ST_FULL], sb.max_held, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/spmq_pkg.sv
hdl/spmq_ram.sv
hdl/spmq_seq.sv
hdl/sorted_priority_message_queue.sv
tb/tb_sorted_priority_message_queue.sv
